### sv/msfq_pkg.sv
// Shared types and constants for the multi-slot FIFO service model.
// No dependencies; imported by the top level, msfq_div and the testbench.
package msfq_pkg;

    localparam int DEF_SLOTS      = 4;
    localparam int DEF_WAIT_DEPTH = 16;
    localparam int MAX_RESULTS    = 20;
    localparam int RES_AW         = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_SUBMIT  = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_DRAIN   = 2'd2;

    localparam logic [1:0] CFG_RATE = 2'd0;
    localparam logic [1:0] CFG_PAR  = 2'd1;
    localparam logic [1:0] CFG_DEV  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUB,
        ST_SCAN,
        ST_SCAN_END,
        ST_TAKE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [63:0] fin;
        logic [63:0] tag;
        logic [63:0] arg_a;
        logic [63:0] arg_b;
        logic [7:0]  stat;
    } t_slot;

    typedef struct packed {
        logic [63:0] tag;
        logic [32:0] dur;
        logic [63:0] arg_a;
        logic [63:0] arg_b;
        logic [7:0]  stat;
    } t_qent;

    typedef struct packed {
        logic [63:0] tag;
        logic [7:0]  stat;
        logic [63:0] arg_a;
        logic [63:0] arg_b;
    } t_res;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

endpackage

### sv/multi_slot_fifo_service_model_top.sv
// Top level of the multi-slot FIFO service model: sequencer, slot registers, scan unit.
// Depends on msfq_pkg, msfq_div and msfq_ram.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  command  | start in, busy out          | i_opcode, i_task_tag, i_service_units,
//           |                             | i_arg_a, i_arg_b, i_delta_time
//  config   | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//  result   | o_valid strobe, one cycle   | o_accepted ... o_next_time
//
// Closing scan: a compare pass over the slots (ST_SCAN), a closing state (ST_SCAN_END)
// and then the emit state. A submit that finds room runs the divider and then the write
// state (ST_SUB) before the closing scan; a bounced submit, advance and other codes skip
// the divider and the write. Drain: each completion takes a scan, a closing and a take
// state (ST_TAKE); results are buffered in a RAM and sent one per cycle after a priming
// step. The last strobe lands in the first idle cycle. Reset is synchronous; no clearing
// pass. The receiver cannot stall the results.
module multi_slot_fifo_service_model_top import msfq_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_task_tag,
    input  logic [31:0] i_service_units,
    input  logic [63:0] i_arg_a,
    input  logic [63:0] i_arg_b,
    input  logic [31:0] i_delta_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_accepted,
    output logic        o_completion_valid,
    output logic [63:0] o_done_tag,
    output logic [7:0]  o_status,
    output logic [63:0] o_value_a,
    output logic [63:0] o_value_b,
    output logic        o_last,
    output logic        o_next_valid,
    output logic [63:0] o_next_time
);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QCW = $clog2(WAIT_DEPTH + 1);
    localparam int QAW = $clog2(WAIT_DEPTH);
    localparam int TW  = QCW + 1;
    localparam int RD  = MAX_RESULTS;
    localparam int RAW = $clog2(RD);

    t_state r_state, n_state;

    logic [31:0] r_rate;
    logic [2:0]  r_par;
    logic [7:0]  r_dev;

    logic [63:0]   r_cur;
    t_slot         r_slot [SLOTS];
    logic [CW-1:0] r_scnt;
    logic [QAW-1:0] r_whead;
    logic [QCW-1:0] r_wcnt;

    logic [1:0]  r_op;
    logic [63:0] r_tag;
    logic [31:0] r_units;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic        r_acc;

    logic [SIW-1:0] r_idx;
    logic [SIW-1:0] r_pick;
    logic           r_found;
    logic           r_due;
    t_slot          r_best;
    logic [63:0]    r_min;
    logic           r_nv;
    logic [63:0]    r_nt;
    logic [RES_AW-1:0] r_n;
    logic [RES_AW-1:0] r_ecnt;
    logic           r_primed;

    logic           r_ov;
    logic           r_oacc;
    logic           r_ocv;
    t_res           r_ores;
    logic           r_olast;
    logic           r_onv;
    logic [63:0]    r_ont;

    // Control decode
    logic        accept;
    logic [4:0]  lim;
    logic        slot_free;
    logic        q_room;
    logic        div_done;
    logic [31:0] quot;
    t_div_req    div_req;
    logic [32:0] dur;
    logic [TW-1:0] tsum;
    logic [QAW-1:0] tail;
    logic [QAW:0]   hinc;
    logic [QAW-1:0] head_nx;
    logic        q_we;
    t_qent       q_wdata;
    t_qent       q_rdata;
    logic        res_we;
    t_res        res_rdata;
    t_slot       sl;
    logic        scan_last;
    logic [CW-1:0] cm1;
    logic        qstart;
    logic        scan_init;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign lim = ({2'b0, r_par} > 5'(SLOTS)) ? 5'(SLOTS) : {2'b0, r_par};
    assign slot_free = 5'(r_scnt) < lim;
    assign q_room    = 7'(r_wcnt) < 7'(WAIT_DEPTH);

    assign dur = (r_units == 32'd0 || r_rate == 32'd0) ? 33'd0 : {1'b0, quot} + 33'd1;

    always_comb begin
        tsum = TW'(r_whead) + TW'(r_wcnt);
        if (tsum >= TW'(WAIT_DEPTH)) begin
            tsum = tsum - TW'(WAIT_DEPTH);
        end
        tail = tsum[QAW-1:0];
        hinc = {1'b0, r_whead} + {{QAW{1'b0}}, 1'b1};
        head_nx = (hinc == (QAW+1)'(WAIT_DEPTH)) ? '0 : hinc[QAW-1:0];
    end

    assign sl        = r_slot[r_idx];
    assign scan_last = ({{(CW-SIW){1'b0}}, r_idx} == r_scnt - CW'(1));
    assign cm1       = r_scnt - CW'(1);
    assign qstart    = (r_wcnt != '0) && (5'(cm1) < lim);
    assign scan_init = (n_state == ST_SCAN) && (r_state != ST_SCAN);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_SUBMIT && (slot_free || q_room)) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_DIV:      n_state = div_done ? ST_SUB : ST_DIV;
            ST_SUB:      n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_scnt == '0 || scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                if (r_op == OP_DRAIN && r_found && r_n < RES_AW'(MAX_RESULTS)) begin
                    n_state = ST_TAKE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_TAKE:     n_state = ST_SCAN;
            ST_EMIT: begin
                if (r_n == '0 || (r_primed && r_ecnt == r_n)) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = i_service_units - 32'd1;
        div_req.divisor  = r_rate;
        q_we             = 1'b0;
        res_we           = 1'b0;
        unique case (r_state)
            ST_IDLE: div_req.start = accept && (i_opcode == OP_SUBMIT) && (slot_free || q_room);
            ST_SUB:  q_we = !slot_free;
            ST_TAKE: res_we = 1'b1;
            default: ;
        endcase
    end

    assign q_wdata = '{tag: r_tag, dur: dur, arg_a: r_a, arg_b: r_b, stat: r_dev};

    msfq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    msfq_ram #(.WIDTH($bits(t_qent)), .DEPTH(WAIT_DEPTH)) u_wait (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (tail),
        .i_wdata (q_wdata),
        .i_raddr (r_whead),
        .o_rdata (q_rdata)
    );

    msfq_ram #(.WIDTH($bits(t_res)), .DEPTH(RD)) u_res (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (r_n[RAW-1:0]),
        .i_wdata ({r_best.tag, r_best.stat, r_best.arg_a, r_best.arg_b}),
        .i_raddr (r_ecnt[RAW-1:0]),
        .o_rdata (res_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rate   <= 32'd1;
            r_par    <= 3'd1;
            r_dev    <= 8'd0;
            r_cur    <= '0;
            r_scnt   <= '0;
            r_whead  <= '0;
            r_wcnt   <= '0;
            r_n      <= '0;
            r_ecnt   <= '0;
            r_primed <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RATE: r_rate <= i_cfg_data;
                    CFG_PAR:  r_par  <= i_cfg_data[2:0];
                    CFG_DEV:  r_dev  <= i_cfg_data[7:0];
                    default:  ;
                endcase
            end
            if (accept) begin
                r_n      <= '0;
                r_ecnt   <= '0;
                r_primed <= 1'b0;
                if (i_opcode == OP_ADVANCE) begin
                    r_cur <= r_cur + {32'd0, i_delta_time};
                end
            end
            if (r_state == ST_SUB) begin
                if (slot_free) begin
                    r_scnt <= r_scnt + CW'(1);
                end else begin
                    r_wcnt <= r_wcnt + QCW'(1);
                end
            end
            if (r_state == ST_TAKE) begin
                r_n <= r_n + RES_AW'(1);
                if (qstart) begin
                    r_whead <= head_nx;
                    r_wcnt  <= r_wcnt - QCW'(1);
                end else begin
                    r_scnt <= cm1;
                end
            end
            if (r_state == ST_EMIT) begin
                if (r_n == '0) begin
                    r_ov <= 1'b1;
                end else if (!r_primed) begin
                    r_primed <= 1'b1;
                    r_ecnt   <= r_ecnt + RES_AW'(1);
                end else begin
                    r_ov   <= 1'b1;
                    r_ecnt <= r_ecnt + RES_AW'(1);
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_tag   <= i_task_tag;
            r_units <= i_service_units;
            r_a     <= i_arg_a;
            r_b     <= i_arg_b;
            r_acc   <= !(i_opcode == OP_SUBMIT) || slot_free || q_room;
        end
        if (r_state == ST_SUB && slot_free) begin
            r_slot[r_scnt[SIW-1:0]] <= '{fin: r_cur + {31'd0, dur}, tag: r_tag,
                                         arg_a: r_a, arg_b: r_b, stat: r_dev};
        end
        if (r_state == ST_TAKE) begin
            // close the gap left by the picked slot, then start the queue head last
            for (int i = 0; i < SLOTS - 1; i++) begin
                if (SIW'(i) >= r_pick) begin
                    r_slot[i] <= r_slot[i + 1];
                end
            end
            if (qstart) begin
                r_slot[cm1[SIW-1:0]] <= '{fin: r_best.fin + {31'd0, q_rdata.dur},
                                          tag: q_rdata.tag, arg_a: q_rdata.arg_a,
                                          arg_b: q_rdata.arg_b, stat: q_rdata.stat};
            end
        end
        if (scan_init) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_due   <= 1'b0;
        end else if (r_state == ST_SCAN && r_scnt != '0) begin
            if (r_idx == '0 || sl.fin < r_min) begin
                r_min <= sl.fin;
            end
            if (sl.fin <= r_cur) begin
                r_due <= 1'b1;
                // strict compare keeps the oldest slot on equal finish times
                if (!r_found || sl.fin < r_best.fin) begin
                    r_found <= 1'b1;
                    r_pick  <= r_idx;
                    r_best  <= sl;
                end
            end
            r_idx <= r_idx + SIW'(1);
        end
        if (r_state == ST_SCAN_END) begin
            r_nv <= (r_scnt != '0);
            r_nt <= (r_scnt == '0) ? 64'd0 : (r_due ? r_cur : r_min);
        end
        if (r_state == ST_EMIT) begin
            r_onv <= r_nv;
            r_ont <= r_nt;
            if (r_n == '0) begin
                r_oacc  <= r_acc;
                r_ocv   <= 1'b0;
                r_ores  <= '0;
                r_olast <= 1'b1;
            end else begin
                r_oacc  <= 1'b1;
                r_ocv   <= 1'b1;
                r_ores  <= res_rdata;
                r_olast <= (r_ecnt == r_n);
            end
        end
    end

    assign o_valid            = r_ov;
    assign o_accepted         = r_oacc;
    assign o_completion_valid = r_ocv;
    assign o_done_tag         = r_ores.tag;
    assign o_status           = r_ores.stat;
    assign o_value_a          = r_ores.arg_a;
    assign o_value_b          = r_ores.arg_b;
    assign o_last             = r_olast;
    assign o_next_valid       = r_onv;
    assign o_next_time        = r_ont;

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_scnt) <= 32'(SLOTS))
        else $error("slot count beyond SLOTS");
    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wcnt) <= 32'(WAIT_DEPTH))
        else $error("wait count beyond depth");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("transfer did not raise busy");
    a_cv_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_completion_valid) |-> o_accepted)
        else $error("completion without accepted");
    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RES_AW'(MAX_RESULTS))
        else $error("result buffer overrun");
endmodule

### sv/msfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/msfq_div.sv
// Restoring 32/32 divider, one quotient bit per cycle.
// Depends on msfq_pkg for the request struct.
module msfq_div import msfq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [32:0] sh;
    logic [32:0] diff;

    always_comb begin
        sh   = {r_rem, r_q[31]};
        diff = sh - {1'b0, r_dvs};
        if (!diff[32]) begin
            n_rem = diff[31:0];
            n_q   = {r_q[30:0], 1'b1};
        end else begin
            n_rem = sh[31:0];
            n_q   = {r_q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### bench/testbench.sv
// Self-checking bench for multi_slot_fifo_service_model_top: directed and random commands,
// a command-level predictor of the slot/queue scheduler, and a result monitor.
// Depends on msfq_pkg and the RTL of the block.
module testbench import msfq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] tag;
        logic [31:0] units;
        logic [63:0] a;
        logic [63:0] b;
        logic [31:0] delta;
    } t_cmd;

    typedef struct {
        logic        acc;
        logic        cv;
        logic [63:0] tag;
        logic [7:0]  st;
        logic [63:0] va;
        logic [63:0] vb;
        logic        last;
        logic        nv;
        logic [63:0] nt;
    } t_exp;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [63:0] i_task_tag = '0;
    logic [31:0] i_service_units = '0;
    logic [63:0] i_arg_a = '0;
    logic [63:0] i_arg_b = '0;
    logic [31:0] i_delta_time = '0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid, o_accepted, o_completion_valid, o_last, o_next_valid;
    logic [63:0] o_done_tag, o_value_a, o_value_b, o_next_time;
    logic [7:0]  o_status;

    multi_slot_fifo_service_model_top dut (.*);

    always #5 i_clk = ~i_clk;

    t_cmd cmd_q[$];
    t_exp sched_results[$];
    int   errors = 0;
    int   n_cmds = 0;
    int   n_done = 0;
    int   n_rejects = 0;
    int   idle_pct = 0;
    bit   running = 0;
    bit   took = 0;

    task automatic add_cmd(t_cmd c);
        cmd_q = {cmd_q, c};
    endtask

    // scheduler shadow state
    logic [31:0] rate_r = 1;
    logic [2:0]  par_r = 1;
    logic [7:0]  dev_r = 0;
    logic [63:0] now_t;
    logic [63:0] s_fin[4], s_tag[4], s_a[4], s_b[4];
    logic [7:0]  s_st[4];
    int          s_cnt;
    logic [63:0] w_tag[16], w_a[16], w_b[16];
    logic [31:0] w_units[16], w_rate[16];
    logic [7:0]  w_st[16];
    int          w_head, w_cnt;

    function automatic int slot_cap();
        return (par_r > 4) ? 4 : int'(par_r);
    endfunction

    function automatic logic [63:0] svc_time(logic [31:0] u, logic [31:0] r);
        if (u == 0 || r == 0) return 64'd0;
        return 64'd1 + 64'(u - 32'd1) / 64'(r);
    endfunction

    task automatic open_slot(logic [63:0] tag, logic [31:0] u, logic [63:0] a,
                             logic [63:0] b, logic [31:0] r, logic [7:0] st,
                             logic [63:0] at);
        if (s_cnt < 4) begin
            s_fin[s_cnt] = at + svc_time(u, r);
            s_tag[s_cnt] = tag;
            s_a[s_cnt]   = a;
            s_b[s_cnt]   = b;
            s_st[s_cnt]  = st;
            s_cnt++;
        end
    endtask

    task automatic sched_step(t_cmd c);
        t_exp r[MAX_RESULTS];
        int n, pick, w;
        logic [63:0] fin, nt;
        logic nv, due;
        n = 0;
        r[0] = '{1'b1, 1'b0, 64'd0, 8'd0, 64'd0, 64'd0, 1'b0, 1'b0, 64'd0};
        if (c.op == OP_SUBMIT) begin
            n = 1;
            if (s_cnt < slot_cap()) begin
                open_slot(c.tag, c.units, c.a, c.b, rate_r, dev_r, now_t);
            end else if (w_cnt < 16) begin
                w = (w_head + w_cnt) % 16;
                w_tag[w] = c.tag; w_units[w] = c.units; w_a[w] = c.a; w_b[w] = c.b;
                w_rate[w] = rate_r; w_st[w] = dev_r;
                w_cnt++;
            end else begin
                r[0].acc = 0;
                n_rejects++;
            end
        end else if (c.op == OP_DRAIN) begin
            while (n < MAX_RESULTS) begin
                pick = s_cnt;
                for (int i = 0; i < s_cnt; i++)
                    if (s_fin[i] <= now_t && (pick == s_cnt || s_fin[i] < s_fin[pick]))
                        pick = i;
                if (pick >= s_cnt) break;
                fin = s_fin[pick];
                r[n] = '{1'b1, 1'b1, s_tag[pick], s_st[pick], s_a[pick], s_b[pick],
                         1'b0, 1'b0, 64'd0};
                n++;
                n_done++;
                for (int i = pick; i + 1 < s_cnt; i++) begin
                    s_fin[i] = s_fin[i+1]; s_tag[i] = s_tag[i+1];
                    s_a[i] = s_a[i+1]; s_b[i] = s_b[i+1]; s_st[i] = s_st[i+1];
                end
                s_cnt--;
                if (w_cnt > 0 && s_cnt < slot_cap()) begin
                    open_slot(w_tag[w_head], w_units[w_head], w_a[w_head], w_b[w_head],
                              w_rate[w_head], w_st[w_head], fin);
                    w_head = (w_head + 1) % 16;
                    w_cnt--;
                end
            end
            if (n == 0) n = 1;
        end else begin
            if (c.op == OP_ADVANCE) now_t += 64'(c.delta);
            n = 1;
        end
        nv = 0; nt = 0; due = 0;
        for (int i = 0; i < s_cnt; i++) begin
            if (s_fin[i] <= now_t) due = 1;
            if (!nv || s_fin[i] < nt) nt = s_fin[i];
            nv = 1;
        end
        if (due) nt = now_t;
        for (int k = 0; k < n; k++) begin
            r[k].last = (k == n - 1);
            r[k].nv   = nv;
            r[k].nt   = nt;
            sched_results = {sched_results, r[k]};
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic cmp(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report(what, got, want);
    endtask

    // monitor: results first, then the command transfer of this edge
    always @(posedge i_clk) begin
        t_exp e;
        if (running && o_valid) begin
            if (sched_results.size() == 0) begin
                report("unexpected result", o_done_tag, 64'd0);
            end else begin
                e = sched_results.pop_front();
                cmp("accepted", o_accepted, e.acc);
                cmp("completion_valid", o_completion_valid, e.cv);
                cmp("done_tag", o_done_tag, e.tag);
                cmp("status", o_status, e.st);
                cmp("value_a", o_value_a, e.va);
                cmp("value_b", o_value_b, e.vb);
                cmp("last", o_last, e.last);
                cmp("next_valid", o_next_valid, e.nv);
                cmp("next_time", o_next_time, e.nt);
            end
        end
        took = running && start && !busy;
        if (took) begin
            sched_step('{i_opcode, i_task_tag, i_service_units, i_arg_a, i_arg_b,
                         i_delta_time});
            n_cmds++;
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_cmd c;
        if (running && (!start || took)) begin
            if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                c = cmd_q.pop_front();
                i_opcode        <= c.op;
                i_task_tag      <= c.tag;
                i_service_units <= c.units;
                i_arg_a         <= c.a;
                i_arg_b         <= c.b;
                i_delta_time    <= c.delta;
                start           <= 1;
            end else begin
                start <= 0;
            end
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_cmd mk(logic [1:0] op, logic [31:0] units, logic [31:0] delta);
        return '{op, rnd64(), units, rnd64(), rnd64(), delta};
    endfunction

    task automatic settle();
        do @(posedge i_clk);
        while (cmd_q.size() > 0 || start || busy || sched_results.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_RATE: rate_r = data;
            CFG_PAR:  par_r  = data[2:0];
            CFG_DEV:  dev_r  = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic t_cmd rnd_cmd();
        int p, q;
        logic [31:0] u, d;
        p = $urandom_range(99);
        q = $urandom_range(99);
        u = (q < 70) ? $urandom_range(20) : (q < 90) ? 32'd0 : $urandom;
        d = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom;
        if (p < 40) return mk(OP_SUBMIT, u, $urandom);
        if (p < 65) return mk(OP_ADVANCE, $urandom, d);
        if (p < 95) return mk(OP_DRAIN, $urandom, $urandom);
        return mk(OP_UNUSED, $urandom, $urandom);
    endfunction

    initial begin
        t_cmd c;
        int pcts[4];
        pcts = '{0, 67, 0, 24};
        now_t = 0; s_cnt = 0; w_head = 0; w_cnt = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        running = 1;

        // saturated parallelism, largest rate, all-ones status
        cfg_write(CFG_RATE, 32'hFFFF_FFFF);
        cfg_write(CFG_PAR, 32'd7);
        cfg_write(CFG_DEV, 32'hFF);
        c = mk(OP_SUBMIT, 32'd0, 0); c.tag = '1; c.a = '1; c.b = '0; add_cmd(c);
        c = mk(OP_SUBMIT, 32'hFFFF_FFFF, 0); c.tag = '0; c.a = '0; c.b = '1;
        add_cmd(c);
        add_cmd(mk(OP_SUBMIT, 32'd1, 0));
        add_cmd(mk(OP_SUBMIT, 32'd5, 0));
        add_cmd(mk(OP_SUBMIT, 32'd3, 0));
        add_cmd(mk(OP_DRAIN, 0, 0));
        add_cmd(mk(OP_UNUSED, '1, '1));
        add_cmd(mk(OP_ADVANCE, 0, 32'd1));
        add_cmd(mk(OP_DRAIN, 0, 0));
        add_cmd(mk(OP_ADVANCE, 0, 32'hFFFF_FFFF));
        add_cmd(mk(OP_DRAIN, 0, 0));
        add_cmd(mk(OP_DRAIN, 0, 0));
        settle();

        // no slots allowed and zero rate: fill the wait queue until a submit bounces
        cfg_write(CFG_PAR, 32'd0);
        cfg_write(CFG_RATE, 32'd0);
        cfg_write(CFG_DEV, 32'h00);
        for (int i = 0; i < 17; i++) add_cmd(mk(OP_SUBMIT, $urandom, 0));
        settle();
        // four slots, then a drain that stops at the result cap and a second drain
        cfg_write(CFG_PAR, 32'd4);
        for (int i = 0; i < 4; i++) add_cmd(mk(OP_SUBMIT, 32'd0, 0));
        add_cmd(mk(OP_DRAIN, 0, 0));
        add_cmd(mk(OP_DRAIN, 0, 0));
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(CFG_RATE, (ph == 3) ? 32'hFFFF_FFFF : $urandom_range(1, 6));
            cfg_write(CFG_PAR, (ph == 2) ? 32'd1 : $urandom_range(2, 4));
            cfg_write(CFG_DEV, $urandom_range(255));
            idle_pct = pcts[ph];
            for (int i = 0; i < 32; i++) begin
                c = rnd_cmd();
                if (i == 20 && ph == 1) c.op = OP_UNUSED;
                add_cmd(c);
                // sender holds off until the block has answered everything
                if (i == 21) begin
                    settle();
                end
            end
            add_cmd(mk(OP_ADVANCE, 0, 32'd1000));
            add_cmd(mk(OP_DRAIN, 0, 0));
            settle();
        end

        $display("ran %0d commands: %0d completions, %0d queue-full rejects",
                 n_cmds, n_done, n_rejects);
        if (errors == 0) begin
            $display("PASS multi_slot_fifo_service_model_top");
        end else begin
            $display("FAIL multi_slot_fifo_service_model_top");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL multi_slot_fifo_service_model_top");
        $finish;
    end
endmodule
